[hw/rtl/csim_pkg.sv]
`timescale 1ns / 1ps

package csim_pkg;

    // default build values
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int MAX_LEN_DEF    = 1024;

    // result format, Q1.15
    localparam int SIM_W   = 16;
    localparam int BIT_W   = 4;
    localparam logic [SIM_W-1:0] SIM_MAX  = 16'h7fff;
    localparam logic [SIM_W-1:0] SIM_ZERO = 16'h0000;

    // operand pairing for the shared shift-add multiplier
    typedef enum logic [1:0] {
        SEL_NORM_PROD = 2'd0,
        SEL_DOT_SQ    = 2'd1,
        SEL_TRIAL     = 2'd2
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic             acc_en;
        logic             mul_start;
        t_mul_sel         mul_sel;
        logic             mul_step;
        logic             cap_p;
        logic             cap_r;
        logic             q_clr;
        logic             sq;
        logic             q_upd;
        logic             load_res;
        logic [BIT_W-1:0] bit_idx;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic norm_zero;
        logic le;
    } t_dp_sts;

endpackage

[hw/rtl/csim_if.sv]
`timescale 1ns / 1ps

// element pair channel
interface csim_in_if #(
    parameter int ELEM_WIDTH = csim_pkg::ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last_pair;

    modport source (output valid, output elem_a, output elem_b, output last_pair,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last_pair,
                    output ready);
endinterface

// similarity result channel
interface csim_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [csim_pkg::SIM_W-1:0]   similarity;
    logic                                norm_zero;
    logic                                too_long;

    modport source (output valid, output similarity, output norm_zero, output too_long,
                    input ready);
    modport sink   (input valid, input similarity, input norm_zero, input too_long,
                    output ready);
endinterface

[hw/rtl/csim_ctrl.sv]
`timescale 1ns / 1ps

module csim_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output csim_pkg::t_ctrl_cmd o_cmd,
    input  csim_pkg::t_dp_sts   i_sts
);

    typedef enum logic [2:0] {
        S_ACC,
        S_CHK,
        S_MP,
        S_MM,
        S_SQ,
        S_ST,
        S_ML,
        S_FIN
    } t_state;

    localparam logic [csim_pkg::BIT_W-1:0] BIT_TOP = 4'd15;

    t_state                       r_state, n_state;
    logic [csim_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic                         r_out_valid, n_out_valid;
    logic                         in_xfer;

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_bit           = r_bit;
        n_out_valid     = r_out_valid;
        o_cmd           = '0;
        o_cmd.mul_sel   = csim_pkg::SEL_NORM_PROD;
        o_cmd.bit_idx   = r_bit;
        o_cmd.acc_en    = in_xfer;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_ACC: begin
                if (in_xfer && i_in_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.norm_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = csim_pkg::SEL_NORM_PROD;
                    n_state         = S_MP;
                end
            end
            S_MP: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_p     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = csim_pkg::SEL_DOT_SQ;
                    n_state         = S_MM;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_MM: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_r = 1'b1;
                    o_cmd.q_clr = 1'b1;
                    n_bit       = BIT_TOP;
                    n_state     = S_SQ;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_ST;
            end
            S_ST: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = csim_pkg::SEL_TRIAL;
                n_state         = S_ML;
            end
            S_ML: begin
                if (i_sts.mul_done) begin
                    o_cmd.q_upd = 1'b1;
                    // full scale passing ends the search, else walk down the bits
                    if ((r_bit == '0) || ((r_bit == BIT_TOP) && i_sts.le)) begin
                        n_state = S_FIN;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_SQ;
                    end
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_res = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // state, bit index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input still ready after last pair");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");
`endif

endmodule

[hw/rtl/csim_dp.sv]
`timescale 1ns / 1ps

module csim_dp #(
    parameter int ELEM_WIDTH = csim_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csim_pkg::MAX_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [ELEM_WIDTH-1:0]        i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]        i_elem_b,
    input  csim_pkg::t_ctrl_cmd                 i_cmd,
    output csim_pkg::t_dp_sts                   o_sts,
    output logic signed [csim_pkg::SIM_W-1:0]   o_similarity,
    output logic                                o_norm_zero,
    output logic                                o_too_long
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PR_W   = 2 * ELEM_WIDTH;
    localparam int ACC_W  = (PR_W + CNT_W > 64) ? 64 : PR_W + CNT_W;
    localparam int SQ_W   = 2 * csim_pkg::SIM_W;
    localparam int Y_W    = (ACC_W > SQ_W) ? ACC_W : SQ_W;
    localparam int P_W    = 2 * ACC_W;
    localparam int M_W    = P_W + SQ_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    // accumulators
    logic [ACC_W-1:0] r_dot, r_na, r_nb;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    // multiplier and search
    logic [M_W-1:0]             r_mx, r_macc, r_r;
    logic [Y_W-1:0]             r_my;
    logic [P_W-1:0]             r_p;
    logic [SQ_W-1:0]            r_s;
    logic [csim_pkg::SIM_W-1:0] r_q;

    // result
    logic [csim_pkg::SIM_W-1:0] r_sim;
    logic                       r_nz, r_too;

    logic signed [PR_W-1:0]     p_ab, p_aa, p_bb;
    logic [ACC_W-1:0]           mag;
    logic                       neg;
    logic [csim_pkg::SIM_W-1:0] trial, sim_val;
    logic                       le;

    assign p_ab  = i_elem_a * i_elem_b;
    assign p_aa  = i_elem_a * i_elem_a;
    assign p_bb  = i_elem_b * i_elem_b;
    assign neg   = r_dot[ACC_W-1];
    assign mag   = neg ? (ACC_W'(0) - r_dot) : r_dot;
    assign trial = r_q | (csim_pkg::SIM_W'(1) << i_cmd.bit_idx);
    assign le    = (r_macc <= r_r);

    assign o_sts.mul_done  = (r_my == '0);
    assign o_sts.norm_zero = (r_na == '0) || (r_nb == '0);
    assign o_sts.le        = le;

    // sums, pair count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_res) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (r_cnt < CNT_MAX) begin
                r_dot <= r_dot + ACC_W'(p_ab);
                r_na  <= r_na + ACC_W'(p_aa);
                r_nb  <= r_nb + ACC_W'(p_bb);
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // shift-add multiplier, one bit of the y operand per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_macc <= '0;
            unique case (i_cmd.mul_sel)
                csim_pkg::SEL_NORM_PROD: begin
                    r_mx <= M_W'(r_na);
                    r_my <= Y_W'(r_nb);
                end
                csim_pkg::SEL_DOT_SQ: begin
                    r_mx <= M_W'(mag);
                    r_my <= Y_W'(mag);
                end
                csim_pkg::SEL_TRIAL: begin
                    r_mx <= M_W'(r_p);
                    r_my <= Y_W'(r_s);
                end
                default: begin
                    r_mx <= '0;
                    r_my <= '0;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            if (r_my[0]) begin
                r_macc <= r_macc + r_mx;
            end
            r_mx <= r_mx << 1;
            r_my <= r_my >> 1;
        end
    end

    // search operands: norm product, scaled dot square, trial square, quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_p) begin
            r_p <= r_macc[P_W-1:0];
        end
        if (i_cmd.cap_r) begin
            r_r <= {r_macc[M_W-31:0], 30'd0};
        end
        if (i_cmd.sq) begin
            r_s <= trial * trial;
        end
        if (i_cmd.q_clr) begin
            r_q <= '0;
        end else if (i_cmd.q_upd && le) begin
            r_q <= trial;
        end
    end

    // signed, saturated result
    always_comb begin
        priority if (o_sts.norm_zero) begin
            sim_val = csim_pkg::SIM_ZERO;
        end else if (neg) begin
            sim_val = csim_pkg::SIM_ZERO - r_q;
        end else if (r_q[csim_pkg::SIM_W-1]) begin
            sim_val = csim_pkg::SIM_MAX;
        end else begin
            sim_val = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_sim <= sim_val;
            r_nz  <= o_sts.norm_zero;
            r_too <= r_ovf;
        end
    end

    assign o_similarity = r_sim;
    assign o_norm_zero  = r_nz;
    assign o_too_long   = r_too;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("pair count beyond limit");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == CNT_MAX))
        else $error("drop flagged before vector was full");
`endif

endmodule

[hw/rtl/cosine_similarity_stream_unit.sv]
`timescale 1ns / 1ps
// element pairs: one transfer per cycle while accumulating, summed in the cycle accepted
// after the last pair the input stalls for the norm check and, for nonzero norms, a
// shift-add multiply per norm product and per dot square, then up to 16 trial steps, each
// a trial square and a shift-add multiply; the result sits in an output register, so
// the next vector streams in
// synchronous active-low reset clears sums, count, drop flag, controller and output valid
module cosine_similarity_stream_unit #(
    parameter int ELEM_WIDTH = csim_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csim_pkg::MAX_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csim_in_if.sink       i_pair,
    csim_out_if.source    o_res
);

    csim_pkg::t_ctrl_cmd cmd;
    csim_pkg::t_dp_sts   sts;

    // sequencing
    csim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pair.valid),
        .i_in_last   (i_pair.last_pair),
        .o_in_ready  (i_pair.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // sums, multiplier and root search
    csim_dp #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_LEN    (MAX_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_a     (i_pair.elem_a),
        .i_elem_b     (i_pair.elem_b),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_similarity (o_res.similarity),
        .o_norm_zero  (o_res.norm_zero),
        .o_too_long   (o_res.too_long)
    );

endmodule
